// File: hdl/bcma_pkg.sv
package bcma_pkg;

    localparam int CFG_W  = 6;
    localparam int TIME_W = 32;

    typedef struct packed {
        logic accept;
        logic val_rd;
        logic update;
        logic div_start;
        logic div_run;
        logic time_rd;
        logic out_load;
        logic finish;
    } bcma_cmd_t;

    typedef struct packed {
        logic plan_empty;
        logic div_done;
        logic out_free;
        logic last_result;
    } bcma_sts_t;

endpackage

// File: hdl/bcma_ram.sv
module bcma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 63
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bcma_datapath.sv
module bcma_datapath
    import bcma_pkg::*;
#(
    parameter int MAX_WINDOW  = 63,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_W-1:0]              cfg_wr_data,
    input  logic [TIME_W-1:0]             in_time,
    input  logic signed [SAMPLE_BITS-1:0] in_value,
    input  logic                          in_end,
    input  logic                          m_tready,
    input  bcma_cmd_t                     cmd,
    output bcma_sts_t                     sts,
    output logic                          out_valid,
    output logic [TIME_W-1:0]             out_time,
    output logic [SAMPLE_BITS-1:0]        out_value,
    output logic                          out_last,
    output logic                          out_short
);

    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DC_W    = $clog2(SUM_W + 1);
    localparam int WW      = (CW > CFG_W) ? CW : CFG_W;
    localparam int ODD_MAX = ((MAX_WINDOW - 1) / 2) * 2 + 1;
    localparam int MAX_RES = MAX_WINDOW / 2 + 1;

    logic [CFG_W-1:0]              cfg_reg;
    logic [CW-1:0]                 win_len_reg;
    logic [AW-1:0]                 ring_pos_reg;
    logic [CW-1:0]                 seen_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [TIME_W-1:0]             time_in_reg;
    logic signed [SAMPLE_BITS-1:0] value_in_reg;
    logic                          end_reg;
    logic [CW-1:0]                 age_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          short_reg;
    logic [SUM_W-1:0]              dvd_reg;
    logic [CW-1:0]                 rem_reg;
    logic                          neg_reg;
    logic [DC_W-1:0]               div_cnt_reg;
    logic                          out_valid_reg;
    logic [TIME_W-1:0]             out_time_reg;
    logic [SAMPLE_BITS-1:0]        out_value_reg;
    logic                          out_last_reg;
    logic                          out_short_reg;

    logic [WW-1:0]                 w_ext;
    logic [CW-1:0]                 eff_win;
    logic [AW-1:0]                 ring_pos_next;
    logic [AW-1:0]                 val_raddr;
    logic [AW-1:0]                 time_raddr;
    logic [SAMPLE_BITS-1:0]        val_rdata;
    logic [TIME_W-1:0]             time_rdata;
    logic                          full;
    logic signed [SUM_W-1:0]       sum_next;
    logic [CW-1:0]                 seen_next;
    logic [CW-1:0]                 half;
    logic [CW:0]                   filled;
    logic [CW:0]                   capped;
    logic [CW-1:0]                 plan_age;
    logic [CW-1:0]                 plan_cnt;
    logic                          plan_short;
    logic [CW:0]                   trial;
    logic                          trial_ge;
    logic [SUM_W-1:0]              quo;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] pos,
                                              input logic [CW-1:0] age);
        logic [CW:0] a;
        logic [CW:0] p;
        logic [CW:0] d;
        a = {1'b0, age};
        if (age >= CW'(MAX_WINDOW)) begin
            a = {1'b0, age} - (CW+1)'(MAX_WINDOW);
        end
        p = (CW+1)'(pos);
        if (p >= a) begin
            d = p - a;
        end else begin
            d = p + (CW+1)'(MAX_WINDOW) - a;
        end
        return AW'(d);
    endfunction

    assign w_ext         = WW'({cfg_reg[CFG_W-1:1], 1'b1});
    assign eff_win       = (w_ext > WW'(ODD_MAX)) ? CW'(ODD_MAX) : CW'(w_ext);
    assign ring_pos_next = (ring_pos_reg == AW'(MAX_WINDOW - 1)) ? '0 : ring_pos_reg + 1'b1;
    assign val_raddr     = slot_of(ring_pos_reg, win_len_reg);
    assign time_raddr    = slot_of(ring_pos_reg, age_reg);

    bcma_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_val_ram (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (ring_pos_reg),
        .wdata (value_in_reg),
        .re    (cmd.val_rd),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    bcma_ram #(.WIDTH(TIME_W), .DEPTH(MAX_WINDOW)) u_time_ram (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (ring_pos_reg),
        .wdata (time_in_reg),
        .re    (cmd.time_rd),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    // running sum and result plan
    always_comb begin
        full       = (seen_reg >= win_len_reg);
        sum_next   = sum_reg + SUM_W'(value_in_reg);
        if (full) begin
            sum_next = sum_next - SUM_W'($signed(val_rdata));
        end
        seen_next  = (seen_reg == CW'(MAX_WINDOW)) ? seen_reg : seen_reg + 1'b1;
        half       = win_len_reg >> 1;
        filled     = (CW+1)'(seen_reg) + 1'b1;
        capped     = (filled > (CW+1)'(MAX_RES)) ? (CW+1)'(MAX_RES) : filled;
        plan_age   = '0;
        plan_cnt   = '0;
        plan_short = 1'b0;
        if (full) begin
            plan_age = half;
            plan_cnt = end_reg ? half + 1'b1 : CW'(1);
        end else if ((filled == {1'b0, win_len_reg}) && !end_reg) begin
            plan_age = win_len_reg - 1'b1;
            plan_cnt = half + 1'b1;
        end else if (end_reg) begin
            plan_age   = CW'(capped - 1'b1);
            plan_cnt   = CW'(capped);
            plan_short = (filled < {1'b0, win_len_reg});
        end
    end

    // restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, win_len_reg});
    assign quo      = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            win_len_reg   <= CW'(1);
            ring_pos_reg  <= '0;
            seen_reg      <= '0;
            sum_reg       <= '0;
            div_cnt_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                ring_pos_reg <= ring_pos_next;
                if (seen_reg == '0) begin
                    win_len_reg <= eff_win;
                end
            end
            if (cmd.update) begin
                sum_reg  <= sum_next;
                seen_reg <= seen_next;
                cnt_reg  <= plan_cnt;
            end
            if (cmd.finish && end_reg) begin
                sum_reg  <= '0;
                seen_reg <= '0;
            end
            if (cmd.div_start) begin
                div_cnt_reg <= DC_W'(SUM_W);
            end else if (cmd.div_run && div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (cmd.out_load) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            time_in_reg  <= in_time;
            value_in_reg <= in_value;
            end_reg      <= in_end;
        end
        if (cmd.update) begin
            age_reg   <= plan_age;
            short_reg <= plan_short;
        end
        if (cmd.div_start) begin
            dvd_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            neg_reg <= sum_reg[SUM_W-1];
            rem_reg <= '0;
        end else if (cmd.div_run && div_cnt_reg != '0) begin
            rem_reg <= trial_ge ? CW'(trial - {1'b0, win_len_reg}) : CW'(trial);
            dvd_reg <= {dvd_reg[SUM_W-2:0], trial_ge};
        end
        if (cmd.out_load) begin
            out_time_reg  <= time_rdata;
            out_value_reg <= quo[SAMPLE_BITS-1:0];
            out_last_reg  <= end_reg && (cnt_reg == CW'(1));
            out_short_reg <= short_reg;
            age_reg       <= age_reg - 1'b1;
        end
    end

    assign sts.plan_empty  = (cnt_reg == '0);
    assign sts.div_done    = (div_cnt_reg == '0);
    assign sts.out_free    = !out_valid_reg || m_tready;
    assign sts.last_result = (cnt_reg == CW'(1));

    assign out_valid = out_valid_reg;
    assign out_time  = out_time_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_short = out_short_reg;

endmodule

// File: hdl/bcma_ctrl.sv
module bcma_ctrl
    import bcma_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bcma_sts_t sts,
    output bcma_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VRD,
        ST_UPD,
        ST_DSTART,
        ST_DIV,
        ST_TRD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_VRD;
                end
            end
            ST_VRD: begin
                cmd.val_rd = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                if (sts.plan_empty) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_TRD;
                end
            end
            ST_TRD: begin
                cmd.time_rd = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.last_result) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_TRD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: hdl/boxcar_moving_average_smoother.sv
// Boxcar moving-average smoother.
// Input stream: s_tdata carries sample_time and sample_value, s_tlast marks the
// final sample of a signal. Output stream: m_tdata carries out_time and
// smoothed_value, m_tlast marks the final point of a signal, m_tuser flags a
// signal shorter than the window. cfg_wr_en/cfg_wr_data set window_request,
// which takes effect at the first sample of the next signal.
// One sample at a time is processed: accept, history read, sum update, then a
// serial divide of the window sum by the window size, one quotient bit per
// cycle (SAMPLE_BITS + clog2(MAX_WINDOW) bits, 22 at the defaults), then for
// each result point a time read and an output load. A sample that makes no
// point ends after the sum update, with no divide.
// Results leave through an output register: when the receiver stalls, the
// point waits there and the block holds until it is taken; after the last
// point of a sample the next sample is accepted while that point still waits.
// Reset (synchronous, active low) clears the window sum, the sample count, the
// window register and the output valid; the history memories are not cleared
// and need no clearing pass.
module boxcar_moving_average_smoother
    import bcma_pkg::*;
#(
    parameter int MAX_WINDOW  = 63,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_wr_en,
    input  logic [CFG_W-1:0]                           cfg_wr_data,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // sample_time, sample_value
    input  logic [((TIME_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                       s_tlast,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // out_time, smoothed_value
    output logic [((TIME_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                       m_tlast,
    // short_stream
    output logic                                       m_tuser
);

    localparam int DATA_W  = TIME_W + SAMPLE_BITS;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

    bcma_cmd_t              cmd;
    bcma_sts_t              sts;
    logic [TIME_W-1:0]      out_time;
    logic [SAMPLE_BITS-1:0] out_value;

    bcma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bcma_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_time     (s_tdata[TIME_W-1:0]),
        .in_value    ($signed(s_tdata[DATA_W-1:TIME_W])),
        .in_end      (s_tlast),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_time    (out_time),
        .out_value   (out_value),
        .out_last    (m_tlast),
        .out_short   (m_tuser)
    );

    assign m_tdata = TDATA_W'({out_value, out_time});

endmodule

// File: hdl/bcma_checker.sv
module bcma_checker
    import bcma_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                               aclk,
    input logic                                               aresetn,
    input logic                                               s_tvalid,
    input logic                                               s_tready,
    input logic                                               m_tvalid,
    input logic                                               m_tready,
    input logic [((TIME_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    // output holds while stalled
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while a sample is in work");

endmodule

bind boxcar_moving_average_smoother bcma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bcma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
